@@ hdl/mcst_pkg.sv @@
package mcst_pkg;

    localparam int NUM_ENTRIES = 128;
    localparam int IDX_W       = $clog2(NUM_ENTRIES);
    localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);
    localparam int NUMBER_W    = 7;
    localparam int ADDR_W      = 4;

    localparam logic [13:0] BEND_CENTER   = 14'd8192;
    localparam logic [6:0]  SEVEN_BIT_MAX = 7'd127;
    localparam logic [7:0]  COUNT_MAX     = 8'd255;

    localparam logic [IDX_W-1:0] CC_MOD_WHEEL  = IDX_W'(1);
    localparam logic [IDX_W-1:0] CC_EXPRESSION = IDX_W'(11);

    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_LISTEN = 2'd1;
    localparam logic [1:0] REG_SMOOTH = 2'd2;

    typedef enum logic [2:0] {
        CMD_NOTE_ON  = 3'd0,
        CMD_NOTE_OFF = 3'd1,
        CMD_CC       = 3'd2,
        CMD_BEND     = 3'd3,
        CMD_AT       = 3'd4,
        CMD_POLY_AT  = 3'd5,
        CMD_TICK     = 3'd6,
        CMD_QUERY    = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BEND,
        ST_AT,
        ST_SWEEP,
        ST_READ,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic        active;
        logic [31:0] age;
        logic [6:0]  raw;
        logic [15:0] smooth;
    } entry_t;

    function automatic logic [6:0] sat7(input logic [13:0] v);
        logic [6:0] r;
        if (v > 14'(SEVEN_BIT_MAX)) begin
            r = SEVEN_BIT_MAX;
        end
        else begin
            r = v[6:0];
        end
        return r;
    endfunction

    // One exponential smoothing step, written as t + (s - t) * f with rounding.
    function automatic logic [15:0] smooth_step(
        input logic signed [16:0] s,
        input logic signed [16:0] t,
        input logic [15:0]        f
    );
        logic signed [17:0] diff;
        logic signed [34:0] prod;
        logic signed [35:0] acc;
        diff = 18'(s) - 18'(t);
        prod = 35'(diff * $signed({1'b0, f}));
        acc  = (36'(t) <<< 16) + 36'(prod) + 36'sd32768;
        return acc[31:16];
    endfunction

endpackage

@@ hdl/mcst_if.sv @@
interface mcst_evt_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [3:0]  midi_channel;
    logic [6:0]  number;
    logic [13:0] data_value;
    logic [15:0] tick_time;

    modport source (
        output valid, cmd, midi_channel, number, data_value, tick_time,
        input  ready
    );
    modport sink (
        input  valid, cmd, midi_channel, number, data_value, tick_time,
        output ready
    );
endinterface

interface mcst_res_if;
    logic               valid;
    logic               ready;
    logic               accepted;
    logic signed [7:0]  last_note;
    logic [6:0]         last_velocity;
    logic [7:0]         note_count;
    logic [15:0]        mod_wheel_smoothed;
    logic [15:0]        expression_smoothed;
    logic signed [15:0] bend_smoothed;
    logic [15:0]        aftertouch_smoothed;
    logic               queried_note_active;
    logic [31:0]        queried_note_age;
    logic [6:0]         queried_cc_raw;
    logic [15:0]        queried_cc_smoothed;

    modport source (
        output valid, accepted, last_note, last_velocity, note_count,
               mod_wheel_smoothed, expression_smoothed, bend_smoothed,
               aftertouch_smoothed, queried_note_active, queried_note_age,
               queried_cc_raw, queried_cc_smoothed,
        input  ready
    );
    modport sink (
        input  valid, accepted, last_note, last_velocity, note_count,
               mod_wheel_smoothed, expression_smoothed, bend_smoothed,
               aftertouch_smoothed, queried_note_active, queried_note_age,
               queried_cc_raw, queried_cc_smoothed,
        output ready
    );
endinterface

@@ hdl/mcst_entry_mem.sv @@
module mcst_entry_mem (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [mcst_pkg::IDX_W-1:0]    rd_addr,
    output mcst_pkg::entry_t              rd_data,
    input  logic                          wr_en,
    input  logic [mcst_pkg::IDX_W-1:0]    wr_addr,
    input  mcst_pkg::entry_t              wr_data
);

    mcst_pkg::entry_t entry_mem [mcst_pkg::NUM_ENTRIES];

    logic [mcst_pkg::NUM_ENTRIES-1:0] valid_reg;
    mcst_pkg::entry_t                 rd_mem_reg;
    logic                             rd_valid_reg;

    // An entry that was never written since reset reads as all zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_mem_reg <= entry_mem[rd_addr];
        end
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_valid_reg ? rd_mem_reg : '0;

endmodule

@@ hdl/midi_channel_state_tracker_top.sv @@
// An event or query passes through the read and update states to a valid result; the update
// waits for a free output register. A tick first smooths bend and aftertouch, then sweeps the
// table, reading and writing back one entry per cycle via the entry memory's separate ports.
// A new item is accepted once the previous one has left the pipeline for the output register.
// Reset is asynchronous and active low; the tables read as zero at once, with no clearing pass.
module midi_channel_state_tracker_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mcst_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    mcst_evt_if.sink                    evt,
    mcst_res_if.source                  res
);

    localparam int IDX_W = mcst_pkg::IDX_W;
    localparam int CNT_W = mcst_pkg::CNT_W;
    localparam int NW    = mcst_pkg::NUMBER_W;

    mcst_pkg::state_t state_reg, state_next;

    logic              enable_reg;
    logic signed [4:0] listen_reg;
    logic [15:0]       factor_reg;

    logic [CNT_W-1:0]  sweep_cnt_reg, sweep_cnt_next;
    logic              mod_valid_reg;
    logic [IDX_W-1:0]  mod_idx_reg;
    logic              out_valid_reg;

    mcst_pkg::cmd_t    cmd_reg;
    logic              acc_reg;
    logic [NW-1:0]     num_reg;
    logic [13:0]       data_reg;
    logic [15:0]       dt_reg;

    logic signed [7:0]  last_note_reg, last_note_next;
    logic [6:0]         last_vel_reg, last_vel_next;
    logic [7:0]         count_reg, count_next;
    logic signed [15:0] bend_raw_reg, bend_raw_next;
    logic signed [15:0] bend_sm_reg;
    logic [6:0]         at_raw_reg, at_raw_next;
    logic [15:0]        at_sm_reg;
    logic [15:0]        mod_sm_reg;
    logic [15:0]        expr_sm_reg;

    logic               res_accepted_reg;
    logic signed [7:0]  res_last_note_reg;
    logic [6:0]         res_last_vel_reg;
    logic [7:0]         res_count_reg;
    logic [15:0]        res_mod_reg;
    logic [15:0]        res_expr_reg;
    logic signed [15:0] res_bend_reg;
    logic [15:0]        res_at_reg;
    logic               res_q_active_reg;
    logic [31:0]        res_q_age_reg;
    logic [6:0]         res_q_raw_reg;
    logic [15:0]        res_q_smooth_reg;

    logic              evt_ready;
    logic              evt_fire;
    logic              evt_acc;
    logic              chan_ok;
    logic              out_free;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              upd_fire;
    logic              sweep_rd;
    logic              in_table;

    mcst_pkg::entry_t  rd_data;
    mcst_pkg::entry_t  sw_entry;
    mcst_pkg::entry_t  upd_entry;
    logic              upd_wr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    mcst_pkg::entry_t  wr_data;

    logic [32:0]        age_sum;
    logic signed [16:0] sm_s;
    logic signed [16:0] sm_t;
    logic [15:0]        sm_out;

    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[3:2])
            mcst_pkg::REG_ENABLE: prdata = {31'd0, enable_reg};
            mcst_pkg::REG_LISTEN: prdata = 32'(listen_reg);
            mcst_pkg::REG_SMOOTH: prdata = {16'd0, factor_reg};
            default:              prdata = 32'd0;
        endcase
    end

    assign chan_ok  = listen_reg[4] || (listen_reg[3:0] == evt.midi_channel);
    assign evt_acc  = (mcst_pkg::cmd_t'(evt.cmd) == mcst_pkg::CMD_QUERY) ? 1'b1 :
                      (mcst_pkg::cmd_t'(evt.cmd) == mcst_pkg::CMD_TICK)  ? enable_reg :
                      (enable_reg && chan_ok);
    assign evt_fire = evt.valid && evt_ready;
    assign out_free = !out_valid_reg || res.ready;
    assign in_table = (NW + 1)'(num_reg) < (NW + 1)'(mcst_pkg::NUM_ENTRIES);
    assign evt.ready = evt_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mcst_pkg::ST_IDLE:
            begin
                if (evt_fire)
                begin
                    if (mcst_pkg::cmd_t'(evt.cmd) == mcst_pkg::CMD_TICK && enable_reg)
                    begin
                        state_next = mcst_pkg::ST_BEND;
                    end
                    else
                    begin
                        state_next = mcst_pkg::ST_READ;
                    end
                end
            end
            mcst_pkg::ST_BEND:
            begin
                state_next = mcst_pkg::ST_AT;
            end
            mcst_pkg::ST_AT:
            begin
                state_next = mcst_pkg::ST_SWEEP;
            end
            mcst_pkg::ST_SWEEP:
            begin
                if (sweep_cnt_reg == CNT_W'(mcst_pkg::NUM_ENTRIES))
                begin
                    state_next = mcst_pkg::ST_READ;
                end
            end
            mcst_pkg::ST_READ:
            begin
                state_next = mcst_pkg::ST_UPDATE;
            end
            mcst_pkg::ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = mcst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mcst_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        evt_ready      = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = num_reg[IDX_W-1:0];
        upd_fire       = 1'b0;
        sweep_rd       = 1'b0;
        sweep_cnt_next = '0;
        case (state_reg)
            mcst_pkg::ST_IDLE:
            begin
                evt_ready = 1'b1;
            end
            mcst_pkg::ST_SWEEP:
            begin
                sweep_rd       = sweep_cnt_reg < CNT_W'(mcst_pkg::NUM_ENTRIES);
                rd_en          = sweep_rd;
                rd_addr        = sweep_cnt_reg[IDX_W-1:0];
                sweep_cnt_next = sweep_cnt_reg + CNT_W'(1);
            end
            mcst_pkg::ST_READ:
            begin
                rd_en = 1'b1;
            end
            mcst_pkg::ST_UPDATE:
            begin
                upd_fire = out_free;
            end
            default:
            begin
                evt_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            mcst_pkg::ST_BEND:
            begin
                sm_s = 17'(bend_sm_reg);
                sm_t = 17'(bend_raw_reg);
            end
            mcst_pkg::ST_AT:
            begin
                sm_s = $signed({1'b0, at_sm_reg});
                sm_t = $signed({1'b0, at_raw_reg, 9'd0});
            end
            default:
            begin
                sm_s = $signed({1'b0, rd_data.smooth});
                sm_t = $signed({1'b0, rd_data.raw, 9'd0});
            end
        endcase
    end

    assign sm_out  = mcst_pkg::smooth_step(sm_s, sm_t, factor_reg);
    assign age_sum = {1'b0, rd_data.age} + 33'(dt_reg);

    always_comb
    begin
        sw_entry        = rd_data;
        sw_entry.smooth = sm_out;
        if (rd_data.active)
        begin
            sw_entry.age = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
        end
    end

    always_comb
    begin
        upd_entry = rd_data;
        upd_wr    = 1'b0;
        if (acc_reg && in_table)
        begin
            case (cmd_reg)
                mcst_pkg::CMD_NOTE_ON:
                begin
                    upd_entry.active = 1'b1;
                    upd_entry.age    = 32'd0;
                    upd_wr           = 1'b1;
                end
                mcst_pkg::CMD_NOTE_OFF:
                begin
                    upd_entry.active = 1'b0;
                    upd_wr           = 1'b1;
                end
                mcst_pkg::CMD_CC:
                begin
                    upd_entry.raw = mcst_pkg::sat7(data_reg);
                    upd_wr        = 1'b1;
                end
                default:
                begin
                    upd_wr = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        last_note_next = last_note_reg;
        last_vel_next  = last_vel_reg;
        count_next     = count_reg;
        bend_raw_next  = bend_raw_reg;
        at_raw_next    = at_raw_reg;
        if (acc_reg)
        begin
            case (cmd_reg)
                mcst_pkg::CMD_NOTE_ON:
                begin
                    last_note_next = $signed({1'b0, num_reg});
                    last_vel_next  = mcst_pkg::sat7(data_reg);
                    if (count_reg != mcst_pkg::COUNT_MAX)
                    begin
                        count_next = count_reg + 8'd1;
                    end
                end
                mcst_pkg::CMD_NOTE_OFF:
                begin
                    if (count_reg != 8'd0)
                    begin
                        count_next = count_reg - 8'd1;
                    end
                end
                mcst_pkg::CMD_BEND:
                begin
                    bend_raw_next = $signed({data_reg - mcst_pkg::BEND_CENTER, 2'b00});
                end
                mcst_pkg::CMD_AT:
                begin
                    at_raw_next = mcst_pkg::sat7(data_reg);
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    assign wr_en   = mod_valid_reg || (upd_fire && upd_wr);
    assign wr_addr = mod_valid_reg ? mod_idx_reg : num_reg[IDX_W-1:0];
    assign wr_data = mod_valid_reg ? sw_entry : upd_entry;

    mcst_entry_mem u_entry_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mcst_pkg::ST_IDLE;
            sweep_cnt_reg <= '0;
            mod_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            enable_reg    <= 1'b1;
            listen_reg    <= -5'sd1;
            factor_reg    <= 16'd0;
            last_note_reg <= -8'sd1;
            last_vel_reg  <= 7'd0;
            count_reg     <= 8'd0;
            bend_raw_reg  <= 16'sd0;
            bend_sm_reg   <= 16'sd0;
            at_raw_reg    <= 7'd0;
            at_sm_reg     <= 16'd0;
            mod_sm_reg    <= 16'd0;
            expr_sm_reg   <= 16'd0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
            mod_valid_reg <= sweep_rd;

            if (psel && penable && pwrite)
            begin
                case (paddr[3:2])
                    mcst_pkg::REG_ENABLE: enable_reg <= pwdata[0];
                    mcst_pkg::REG_LISTEN: listen_reg <= $signed(pwdata[4:0]);
                    mcst_pkg::REG_SMOOTH: factor_reg <= pwdata[15:0];
                    default:              factor_reg <= factor_reg;
                endcase
            end

            if (state_reg == mcst_pkg::ST_BEND)
            begin
                bend_sm_reg <= $signed(sm_out);
            end
            if (state_reg == mcst_pkg::ST_AT)
            begin
                at_sm_reg <= sm_out;
            end
            if (mod_valid_reg && mod_idx_reg == mcst_pkg::CC_MOD_WHEEL)
            begin
                mod_sm_reg <= sm_out;
            end
            if (mod_valid_reg && mod_idx_reg == mcst_pkg::CC_EXPRESSION)
            begin
                expr_sm_reg <= sm_out;
            end

            if (upd_fire)
            begin
                last_note_reg <= last_note_next;
                last_vel_reg  <= last_vel_next;
                count_reg     <= count_next;
                bend_raw_reg  <= bend_raw_next;
                at_raw_reg    <= at_raw_next;
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_fire)
        begin
            cmd_reg  <= mcst_pkg::cmd_t'(evt.cmd);
            acc_reg  <= evt_acc;
            num_reg  <= evt.number;
            data_reg <= evt.data_value;
            dt_reg   <= evt.tick_time;
        end
        mod_idx_reg <= sweep_cnt_reg[IDX_W-1:0];
        if (upd_fire)
        begin
            res_accepted_reg  <= acc_reg;
            res_last_note_reg <= last_note_next;
            res_last_vel_reg  <= last_vel_next;
            res_count_reg     <= count_next;
            res_mod_reg       <= mod_sm_reg;
            res_expr_reg      <= expr_sm_reg;
            res_bend_reg      <= bend_sm_reg;
            res_at_reg        <= at_sm_reg;
            res_q_active_reg  <= in_table && upd_entry.active;
            res_q_age_reg     <= in_table ? upd_entry.age : 32'd0;
            res_q_raw_reg     <= in_table ? upd_entry.raw : 7'd0;
            res_q_smooth_reg  <= in_table ? upd_entry.smooth : 16'd0;
        end
    end

    assign res.valid               = out_valid_reg;
    assign res.accepted            = res_accepted_reg;
    assign res.last_note           = res_last_note_reg;
    assign res.last_velocity       = res_last_vel_reg;
    assign res.note_count          = res_count_reg;
    assign res.mod_wheel_smoothed  = res_mod_reg;
    assign res.expression_smoothed = res_expr_reg;
    assign res.bend_smoothed       = res_bend_reg;
    assign res.aftertouch_smoothed = res_at_reg;
    assign res.queried_note_active = res_q_active_reg;
    assign res.queried_note_age    = res_q_age_reg;
    assign res.queried_cc_raw      = res_q_raw_reg;
    assign res.queried_cc_smoothed = res_q_smooth_reg;

    // The sweep write-back stage is only busy during a sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        mod_valid_reg |-> state_reg == mcst_pkg::ST_SWEEP)
        else $error("sweep write-back outside of a sweep");

    // A read never meets a pending write to the same entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en && rd_addr == wr_addr))
        else $error("read and write to the same entry in one cycle");

    // The query read follows the last sweep write-back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mcst_pkg::ST_SWEEP &&
         sweep_cnt_reg == CNT_W'(mcst_pkg::NUM_ENTRIES))
        |=> state_reg == mcst_pkg::ST_READ && !mod_valid_reg)
        else $error("sweep did not end in the query read");

    // A finished item always lands in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        upd_fire |=> out_valid_reg && state_reg == mcst_pkg::ST_IDLE)
        else $error("result transfer lost");

endmodule
